/* rtl/core/plk_pkg.sv */
package plk_pkg;

  localparam int PATH_DEPTH_DEF  = 1024;
  localparam int START_INDEX_DEF = 50;

  localparam int COORD_W    = 32;
  localparam int DIST_W     = 20;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int STEP_W     = 8;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int GOAL_IDX_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_STEP  = 1'b1;

  // command codes
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_POSE  = 1'b1;

  localparam logic [DIST_W-1:0] TARGET_DIST_RST = 20'd5120;
  localparam logic [STEP_W-1:0] INDEX_STEP_RST  = 8'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } plk_point_t;

  typedef struct packed {
    logic done;
    logic close;
  } plk_dist_res_t;

endpackage

/* rtl/core/path_lookahead_point_selector.sv */
// Path point: written to the path memory at the transfer edge, no result, busy stays low.
// Pose with no path loaded: result strobed in the cycle after the transfer.
// Pose with a path: k distance checks (memory read, difference, squares, compare); result
// registered after the last compare, or after a fetch of the last point on running off
// the path end. The next item is taken in the cycle the result is shown; no stall input.
// Reset (synchronous): empty path, goal index START_INDEX, registers 5.0 m and step 5.
module path_lookahead_point_selector #(
  parameter int PATH_DEPTH  = plk_pkg::PATH_DEPTH_DEF,
  parameter int START_INDEX = plk_pkg::START_INDEX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic signed [plk_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [plk_pkg::COORD_W-1:0]    in_pos_y,
  input  logic                                  in_first_point,
  output logic                                  out_strobe,
  output logic signed [plk_pkg::COORD_W-1:0]    out_goal_x,
  output logic signed [plk_pkg::COORD_W-1:0]    out_goal_y,
  output logic [plk_pkg::GOAL_IDX_W-1:0]        out_goal_point_index,
  output logic                                  out_goal_valid,
  input  logic                                  cfg_we,
  input  logic [plk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [plk_pkg::CFG_W-1:0]             cfg_wdata
);
  import plk_pkg::*;

  localparam int IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int LEN_W = $clog2(PATH_DEPTH + 1);
  localparam int GI_W  = (IDX_W > GOAL_IDX_W) ? IDX_W : GOAL_IDX_W;
  localparam logic [LEN_W-1:0] DEPTH_L   = LEN_W'(PATH_DEPTH);
  localparam logic [GI_W-1:0]  START_IDX = GI_W'(START_INDEX);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_SQR   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_FETCH = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [GI_W-1:0]           goal_idx_r, goal_idx_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic                      loaded_r, loaded_nxt;
  logic [DIST_W-1:0]         tdist_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [COORD_W-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic                      out_strobe_r, out_strobe_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [GOAL_IDX_W-1:0]     out_idx_r, out_idx_nxt;

  logic                      accept;
  logic [GI_W:0]             len_ext, last_ext, goal_ext, next_ext;
  logic [STEP_W-1:0]         step_eff;
  logic                      pt_we;
  logic [IDX_W-1:0]          wr_addr;
  logic                      rd_en;
  plk_point_t                wr_point, rd_point;
  plk_dist_res_t             dist_res;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign len_ext  = (GI_W+1)'(len_r);
  assign last_ext = len_ext - (GI_W+1)'(1);
  assign goal_ext = {1'b0, goal_idx_r};
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
  assign next_ext = goal_ext + (GI_W+1)'(step_eff);

  // points beyond the depth are dropped; a first point always lands at entry 0
  assign pt_we    = accept && (in_command == CMD_POINT) &&
                    (in_first_point || (len_r < DEPTH_L));
  assign wr_addr  = in_first_point ? '0 : len_r[IDX_W-1:0];
  assign wr_point = '{x: in_pos_x, y: in_pos_y};
  assign rd_en    = (state_r == S_READ) || (state_r == S_FETCH);

  plk_path_mem #(
    .DEPTH (PATH_DEPTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (wr_addr),
    .wr_data (wr_point),
    .rd_en   (rd_en),
    .rd_addr (goal_idx_r[IDX_W-1:0]),
    .rd_data (rd_point)
  );

  plk_dist_unit u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_en     (state_r == S_DIFF),
    .point     (rd_point),
    .pose_x    (pose_x_r),
    .pose_y    (pose_y_r),
    .look_dist (tdist_r),
    .res       (dist_res)
  );

  always_comb begin
    state_nxt      = state_r;
    goal_idx_nxt   = goal_idx_r;
    len_nxt        = len_r;
    loaded_nxt     = loaded_r;
    pose_x_nxt     = pose_x_r;
    pose_y_nxt     = pose_y_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_idx_nxt    = out_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_POINT) begin
            if (pt_we) begin
              len_nxt    = in_first_point ? LEN_W'(1) : LEN_W'(len_r + LEN_W'(1));
              loaded_nxt = 1'b1;
            end
          end else if (!loaded_r || (len_r == '0)) begin
            out_strobe_nxt = 1'b1;
            out_valid_nxt  = 1'b0;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_idx_nxt    = '0;
          end else begin
            pose_x_nxt = in_pos_x;
            pose_y_nxt = in_pos_y;
            // clamp a stale index before any read
            if (goal_ext >= len_ext) begin
              goal_idx_nxt = last_ext[GI_W-1:0];
            end
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQR;
      S_SQR:  state_nxt = S_CMP;
      S_CMP: begin
        if (dist_res.close) begin
          if (next_ext >= len_ext) begin
            goal_idx_nxt = last_ext[GI_W-1:0];
            state_nxt    = S_FETCH;
          end else begin
            goal_idx_nxt = next_ext[GI_W-1:0];
            state_nxt    = S_READ;
          end
        end else begin
          out_strobe_nxt = 1'b1;
          out_valid_nxt  = 1'b1;
          out_x_nxt      = rd_point.x;
          out_y_nxt      = rd_point.y;
          out_idx_nxt    = GOAL_IDX_W'(goal_idx_r);
          state_nxt      = S_IDLE;
        end
      end
      S_FETCH: state_nxt = S_EMIT;
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        out_x_nxt      = rd_point.x;
        out_y_nxt      = rd_point.y;
        out_idx_nxt    = GOAL_IDX_W'(goal_idx_r);
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      goal_idx_r   <= START_IDX;
      len_r        <= '0;
      loaded_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      tdist_r      <= TARGET_DIST_RST;
      step_r       <= INDEX_STEP_RST;
    end else begin
      state_r      <= state_nxt;
      goal_idx_r   <= goal_idx_nxt;
      len_r        <= len_nxt;
      loaded_r     <= loaded_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET_DIST: tdist_r <= cfg_wdata[DIST_W-1:0];
          CFG_INDEX_STEP:  step_r  <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pose_x_r    <= pose_x_nxt;
    pose_y_r    <= pose_y_nxt;
    out_valid_r <= out_valid_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_strobe           = out_strobe_r;
  assign out_goal_x           = out_x_r;
  assign out_goal_y           = out_y_r;
  assign out_goal_point_index = out_idx_r;
  assign out_goal_valid       = out_valid_r;

  // every memory read stays inside the stored path
  a_read_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (goal_ext < len_ext))
    else $error("path read beyond stored length");

  // a valid goal points at a stored entry and the search has finished
  a_goal_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_goal_valid) |-> ((goal_ext < len_ext) && (state_r == S_IDLE)))
    else $error("valid goal outside path or search still running");

  // a pose with no path gives an invalid result in the next cycle
  a_no_path_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_POSE) && !loaded_r) |=> (out_strobe && !out_goal_valid))
    else $error("missing invalid result for pose without path");

  // distance result arrives exactly at the compare step
  a_dist_timing: assert property (@(posedge clk) disable iff (!rst_n)
    dist_res.done == (state_r == S_CMP))
    else $error("distance result out of step with control");

endmodule

/* rtl/core/plk_path_mem.sv */
module plk_path_mem #(
  parameter int DEPTH = plk_pkg::PATH_DEPTH_DEF,
  parameter int AW    = $clog2(plk_pkg::PATH_DEPTH_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  plk_pkg::plk_point_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output plk_pkg::plk_point_t rd_data
);
  import plk_pkg::*;

  plk_point_t mem [DEPTH];
  plk_point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/plk_dist_unit.sv */
module plk_dist_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_en,
  input  plk_pkg::plk_point_t                 point,
  input  logic signed [plk_pkg::COORD_W-1:0]  pose_x,
  input  logic signed [plk_pkg::COORD_W-1:0]  pose_y,
  input  logic [plk_pkg::DIST_W-1:0]          look_dist,
  output plk_pkg::plk_dist_res_t              res
);
  import plk_pkg::*;

  logic [COORD_W:0]  dx, dy;
  logic [COORD_W:0]  ax, ay;
  logic              far;

  logic              v1_r, v2_r;
  logic              far1_r, far2_r;
  logic [DIST_W-1:0] ax_r, ay_r, td1_r;
  logic [SQ_W-1:0]   sx_r, sy_r, tt_r;
  logic [SQ_W:0]     sum;

  always_comb begin
    dx  = {point.x[COORD_W-1], point.x} - {pose_x[COORD_W-1], pose_x};
    dy  = {point.y[COORD_W-1], point.y} - {pose_y[COORD_W-1], pose_y};
    ax  = dx[COORD_W] ? ((COORD_W+1)'(0) - dx) : dx;
    ay  = dy[COORD_W] ? ((COORD_W+1)'(0) - dy) : dy;
    // a component of 2^20 or more is always far enough
    far = (|ax[COORD_W:DIST_W]) || (|ay[COORD_W:DIST_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en) begin
      ax_r   <= ax[DIST_W-1:0];
      ay_r   <= ay[DIST_W-1:0];
      td1_r  <= look_dist;
      far1_r <= far;
    end
    if (v1_r) begin
      sx_r   <= ax_r * ax_r;
      sy_r   <= ay_r * ay_r;
      tt_r   <= td1_r * td1_r;
      far2_r <= far1_r;
    end
  end

  assign sum       = {1'b0, sx_r} + {1'b0, sy_r};
  assign res.done  = v2_r;
  assign res.close = !far2_r && (sum < {1'b0, tt_r});

endmodule

/* sim/plk_goal_check_pkg.sv */
`timescale 1ns / 100ps
package plk_goal_check_pkg;
  import plk_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [GOAL_IDX_W-1:0]     index;
    logic                      valid;
  } goal_result_t;

  class goal_scoreboard;
    logic signed [COORD_W-1:0] path_x [PATH_DEPTH_DEF];
    logic signed [COORD_W-1:0] path_y [PATH_DEPTH_DEF];
    int unsigned               path_len;
    int unsigned               goal_idx;
    bit                        loaded;
    logic [DIST_W-1:0]         target_dist;
    logic [STEP_W-1:0]         step_size;
    goal_result_t              goals_due [$];
    int unsigned               mismatches;
    int unsigned               results_seen;
    int unsigned               points_kept;
    int unsigned               points_dropped;
    int unsigned               poses_seen;
    int unsigned               end_hits;
    int unsigned               stale_clamps;

    function new();
      path_len    = 0;
      goal_idx    = START_INDEX_DEF;
      loaded      = 1'b0;
      target_dist = TARGET_DIST_RST;
      step_size   = INDEX_STEP_RST;
    endfunction

    function void set_registers(logic [DIST_W-1:0] reach, logic [STEP_W-1:0] stride);
      target_dist = reach;
      step_size   = stride;
    endfunction

    // squared compare; a coordinate gap of 2^20 or more never counts as near
    function bit point_near(int unsigned idx, longint px, longint py);
      longint dx, dy, lim;
      dx = longint'(path_x[idx]) - px;
      dy = longint'(path_y[idx]) - py;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx >= 64'sd1048576 || dy >= 64'sd1048576) return 1'b0;
      lim = longint'(target_dist);
      return (dx * dx + dy * dy) < (lim * lim);
    endfunction

    function void note_transfer(logic cmd, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y, logic first);
      goal_result_t g;
      int unsigned  last, stride, next;
      longint       px, py;
      if (cmd == CMD_POINT) begin
        if (first) path_len = 0;
        if (path_len < PATH_DEPTH_DEF) begin
          path_x[path_len] = x;
          path_y[path_len] = y;
          path_len++;
          loaded = 1'b1;
          points_kept++;
        end else begin
          points_dropped++;
        end
        return;
      end
      poses_seen++;
      if (!loaded || path_len == 0) begin
        g = '0;
        goals_due.push_back(g);
        return;
      end
      px     = longint'(x);
      py     = longint'(y);
      last   = path_len - 1;
      stride = (step_size == 0) ? 1 : step_size;
      if (goal_idx > last) begin
        goal_idx = last;
        stale_clamps++;
      end
      while (point_near(goal_idx, px, py)) begin
        next = goal_idx + stride;
        if (next > last) begin
          goal_idx = last;
          end_hits++;
          break;
        end
        goal_idx = next;
      end
      g.x     = path_x[goal_idx];
      g.y     = path_y[goal_idx];
      g.index = GOAL_IDX_W'(goal_idx);
      g.valid = 1'b1;
      goals_due.push_back(g);
    endfunction

    function void check_goal(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic [GOAL_IDX_W-1:0] index, logic valid);
      goal_result_t want;
      results_seen++;
      if (goals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: goal with none pending: x=%0d y=%0d index=%0d valid=%b",
                   $time, x, y, index, valid);
        return;
      end
      want = goals_due.pop_front();
      if (want.x !== x || want.y !== y || want.index !== index || want.valid !== valid) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: goal mismatch, expected x=%0d y=%0d index=%0d valid=%b",
                   $time, want.x, want.y, want.index, want.valid);
          $display("%0t:                  actual x=%0d y=%0d index=%0d valid=%b",
                   $time, x, y, index, valid);
        end
      end
    endfunction

    function int unsigned outstanding();
      return goals_due.size();
    endfunction
  endclass

endpackage

/* sim/path_lookahead_point_selector_test.sv */
`timescale 1ns / 100ps
module path_lookahead_point_selector_test;
  import plk_pkg::*;
  import plk_goal_check_pkg::*;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic                         in_command     = CMD_POINT;
  logic signed [COORD_W-1:0]    in_pos_x       = '0;
  logic signed [COORD_W-1:0]    in_pos_y       = '0;
  logic                         in_first_point = 1'b0;
  logic                         out_strobe;
  logic signed [COORD_W-1:0]    out_goal_x;
  logic signed [COORD_W-1:0]    out_goal_y;
  logic [GOAL_IDX_W-1:0]        out_goal_point_index;
  logic                         out_goal_valid;
  logic                         cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index      = CFG_TARGET_DIST;
  logic [CFG_W-1:0]             cfg_wdata      = '0;

  goal_scoreboard sb;
  int unsigned    idle_pct   = 0;
  int unsigned    items_sent = 0;

  localparam int LONG_Y = -268435456;

  path_lookahead_point_selector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_first_point       (in_first_point),
    .out_strobe           (out_strobe),
    .out_goal_x           (out_goal_x),
    .out_goal_y           (out_goal_y),
    .out_goal_point_index (out_goal_point_index),
    .out_goal_valid       (out_goal_valid),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #2 clk = ~clk;

  // note the transfer first: a new item may be taken in the cycle a goal is shown
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_transfer(in_command, in_pos_x, in_pos_y, in_first_point);
      if (out_strobe)
        sb.check_goal(out_goal_x, out_goal_y, out_goal_point_index, out_goal_valid);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned n;
    n = 0;
    while ($urandom_range(99) < idle_pct && n < 40) n++;
    return n;
  endfunction

  task automatic send_item(input logic cmd, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input logic first);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_first_point <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // hold off until every pending goal has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_registers(input logic [DIST_W-1:0] reach,
                                 input logic [STEP_W-1:0] stride);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_DIST;
    cfg_wdata <= CFG_W'(reach);
    @(posedge clk);
    cfg_index <= CFG_INDEX_STEP;
    cfg_wdata <= CFG_W'(stride);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_registers(reach, stride);
  endtask

  // pose close to the current goal (or some stored point) so the search walks
  task automatic pose_near();
    int unsigned idx;
    int          span, ox, oy;
    if (sb.path_len == 0) begin
      send_item(CMD_POSE, $urandom, $urandom, 1'($urandom_range(1)));
      return;
    end
    idx = (sb.goal_idx < sb.path_len) ? sb.goal_idx : sb.path_len - 1;
    if ($urandom_range(3) == 0) idx = $urandom_range(sb.path_len - 1);
    if (sb.target_dist == 0) span = 1024;
    else if (sb.target_dist > 20'd262144) span = 262144;
    else span = int'(sb.target_dist);
    ox = int'($urandom_range(2 * span)) - span;
    oy = int'($urandom_range(2 * span)) - span;
    send_item(CMD_POSE, sb.path_x[idx] + ox, sb.path_y[idx] + oy, 1'($urandom_range(1)));
  endtask

  task automatic walk_path();
    int unsigned               len, n;
    int                        dx, dy;
    bit                        append;
    logic signed [COORD_W-1:0] x, y;
    len    = $urandom_range(40, 2);
    append = ($urandom_range(9) == 0) && (sb.path_len != 0);
    if (append) begin
      x = sb.path_x[sb.path_len - 1];
      y = sb.path_y[sb.path_len - 1];
    end else begin
      x = $urandom;
      y = $urandom;
    end
    dx = int'($urandom_range(4096)) - 2048;
    dy = int'($urandom_range(4096)) - 2048;
    for (int i = 0; i < len; i++) begin
      x = x + dx + int'($urandom_range(256)) - 128;
      y = y + dy + int'($urandom_range(256)) - 128;
      send_item(CMD_POINT, x, y, (i == 0) && !append);
    end
    n = $urandom_range(8, 2);
    repeat (n) pose_near();
  endtask

  initial begin
    int unsigned       pct_tab [5];
    logic [DIST_W-1:0] dist_tab [5];
    logic [STEP_W-1:0] step_tab [5];
    int unsigned       phase_end, pick;
    sb = new();
    pct_tab  = '{0, 83, 0, 16, 83};
    dist_tab = '{20'hFFFFF, 20'd0, DIST_W'($urandom_range(12000, 2048)), 20'd7000,
                 DIST_W'($urandom_range(20000, 1))};
    step_tab = '{8'd1, 8'd255, 8'd0, STEP_W'($urandom_range(6, 1)),
                 STEP_W'($urandom_range(16, 1))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no path loaded yet: goals come back invalid
    send_item(CMD_POSE, 0, 0, 1'b0);
    send_item(CMD_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // points without a start flag still build a path
    for (int i = 0; i < 4; i++) send_item(CMD_POINT, i * 1024, 0, 1'b0);
    send_item(CMD_POSE, 0, 0, 1'b1);               // start index beyond the path
    send_item(CMD_POSE, 3072, 0, 1'b0);            // step runs past the last point
    send_item(CMD_POSE, 3072 + 1048576, 0, 1'b0);  // gap of exactly 2^20
    // new path keeps the old goal index
    for (int i = 0; i < 16; i++) send_item(CMD_POINT, i * 1024, 1024, i == 0);
    send_item(CMD_POSE, 3072, 1024, 1'b0);
    settle();
    write_registers(20'hFFFFF, 8'd0);
    send_item(CMD_POSE, 8192 - 1048575, 1024, 1'b0);
    send_item(CMD_POSE, 9216 + 1048576, 1024, 1'b0);
    send_item(CMD_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(CMD_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    settle();
    write_registers(20'd0, 8'd1);
    send_item(CMD_POSE, 9216, 1024, 1'b0);
    settle();

    // fill the whole path memory, then overflow it
    for (int i = 0; i < PATH_DEPTH_DEF + 2; i++)
      send_item(CMD_POINT, i * 512 - 262144, LONG_Y, i == 0);
    send_item(CMD_POSE, -262144, LONG_Y, 1'b0);
    settle();
    write_registers(20'hFFFFF, 8'd1);
    send_item(CMD_POSE, 0, LONG_Y, 1'b0);
    settle();
    write_registers(20'd3000, 8'd255);
    send_item(CMD_POSE, $urandom, $urandom, 1'b0);
    send_item(CMD_POINT, $urandom, $urandom, 1'b0);
    send_item(CMD_POSE, -262144, LONG_Y, 1'b0);

    for (int p = 0; p < 5; p++) begin
      settle();
      idle_pct = pct_tab[p];
      write_registers(dist_tab[p], step_tab[p]);
      phase_end = items_sent + 120;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) walk_path();
        else if (pick < 82) send_item(CMD_POSE, $urandom, $urandom, 1'($urandom_range(1)));
        else if (pick < 94) send_item(CMD_POINT, $urandom, $urandom, 1'($urandom_range(1)));
        else settle();
      end
    end
    settle();
    repeat (20) @(posedge clk);

    $display("Stored %0d path points, dropped %0d past the depth, %0d pose updates, %0d goals",
             sb.points_kept, sb.points_dropped, sb.poses_seen, sb.results_seen);
    $display("%0d searches ran into the path end, %0d stale goal indexes clamped",
             sb.end_hits, sb.stale_clamps);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d goals never returned", sb.mismatches, sb.outstanding());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(250_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
